FILE: rtl/fesm_pkg.sv
`default_nettype none
package fesm_pkg;

   // slot pool geometry
   localparam int SLOT_COUNT = 16;
   localparam int FIRST_SLOT = 1;
   localparam int CELL_COUNT = SLOT_COUNT - FIRST_SLOT + 1;
   localparam int SLOT_W = $clog2(SLOT_COUNT + 1);
   localparam int MASK_W = 17;

   // index and notice codes
   localparam logic [7:0] ALL_INDEX = 8'hFF;
   localparam logic [6:0] ALL_NOTICE = 7'h7F;

   // device status bits
   localparam logic [4:0] ST_PAUSED = 5'h01;
   localparam logic [4:0] ST_ENABLED = 5'h02;
   localparam logic [4:0] ST_SAFETY = 5'h04;
   localparam logic [4:0] ST_OVERRIDE = 5'h08;
   localparam logic [4:0] ST_POWER = 5'h10;

   // device control codes
   localparam logic [7:0] CTL_DISABLE = 8'd1;
   localparam logic [7:0] CTL_ENABLE = 8'd2;
   localparam logic [7:0] CTL_STOP_ALL = 8'd3;
   localparam logic [7:0] CTL_RESET = 8'd4;
   localparam logic [7:0] CTL_PAUSE = 8'd5;
   localparam logic [7:0] CTL_CONTINUE = 8'd6;

   typedef enum logic [2:0] {
      CMD_CREATE = 3'd0,
      CMD_START = 3'd1,
      CMD_SOLO = 3'd2,
      CMD_STOP = 3'd3,
      CMD_FREE = 3'd4,
      CMD_CTRL = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] slot_index;
      logic [7:0] control_code;
   } req_type;

   typedef struct packed {
      logic [4:0] new_index;
      logic       load_status;
      logic [4:0] device_status;
      logic       auto_centre;
      logic       notify_start;
      logic       notify_stop;
      logic       notify_free;
      logic [6:0] notify_index;
   } rsp_type;

   // command token travelling along the slot cells
   typedef struct packed {
      logic              valid;
      logic [2:0]        cmd;
      logic [7:0]        idx;
      logic [7:0]        ctl;
      logic              found;
      logic [SLOT_W-1:0] new_idx;
      logic              hit_alloc;
   } link_type;

endpackage
`default_nettype wire

FILE: rtl/fesm_cell.sv
`default_nettype none
module fesm_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [fesm_pkg::SLOT_W-1:0] cell_id,
   input  wire fesm_pkg::link_type        link_prev,
   output fesm_pkg::link_type             link_next
);
   import fesm_pkg::*;

   logic     alloc_ff, alloc_in;
   logic     play_ff, play_in;
   link_type link_ff, link_in;
   logic     hit;
   logic     clear;

   assign hit = (link_prev.idx == 8'(cell_id));
   assign clear = ((link_prev.cmd == CMD_FREE) && (link_prev.idx == ALL_INDEX)) ||
                  ((link_prev.cmd == CMD_CTRL) && (link_prev.ctl == CTL_RESET));

   // apply this slot's share of the command, pass the token on
   always_comb begin
      alloc_in = alloc_ff;
      play_in = play_ff;
      link_in = link_prev;
      if (link_prev.valid) begin
         if (clear) begin
            alloc_in = 1'b0;
            play_in = 1'b0;
         end else begin
            unique case (link_prev.cmd)
               CMD_CREATE: begin
                  if (!link_prev.found && !alloc_ff) begin
                     alloc_in = 1'b1;
                     play_in = 1'b0;
                     link_in.found = 1'b1;
                     link_in.new_idx = cell_id;
                  end
               end
               CMD_START: begin
                  if (hit && alloc_ff) play_in = 1'b1;
               end
               CMD_SOLO: begin
                  play_in = hit && alloc_ff;
               end
               CMD_STOP: begin
                  if (hit) begin
                     link_in.hit_alloc = alloc_ff;
                     play_in = 1'b0;
                  end
               end
               CMD_FREE: begin
                  if (hit) begin
                     alloc_in = 1'b0;
                     play_in = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // slot flags and token register
   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff <= 1'b0;
         play_ff <= 1'b0;
         link_ff.valid <= 1'b0;
      end else begin
         alloc_ff <= alloc_in;
         play_ff <= play_in;
         link_ff.valid <= link_in.valid;
      end
      link_ff.cmd <= link_in.cmd;
      link_ff.idx <= link_in.idx;
      link_ff.ctl <= link_in.ctl;
      link_ff.found <= link_in.found;
      link_ff.new_idx <= link_in.new_idx;
      link_ff.hit_alloc <= link_in.hit_alloc;
   end

   assign link_next = link_ff;

endmodule
`default_nettype wire

FILE: rtl/ffb_effect_slot_manager.sv
`default_nettype none
// Force-feedback effect slot manager. Each accepted command item walks a
// row of slot cells, one cell per cycle, each cell holding the allocated and
// playing bits of one slot; create claims the first free cell it meets, so
// the lowest free slot is always taken. The token leaving the last cell
// is captured in the finish register, and the result item is then loaded
// into the output register once it is empty or not stalled. The next command
// is taken in the cycle after the result is loaded, so one command is
// handled at a time; a stalled earlier result holds the finish state. The
// result waits in an output register while the next command runs. All slots
// are free after reset; the disabled_slots mask only hides driver notices.
module ffb_effect_slot_manager (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire fesm_pkg::req_type           req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output fesm_pkg::rsp_type                rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [fesm_pkg::MASK_W-1:0] csr_wr_data
);
   import fesm_pkg::*;

   state_type         state_ff, state_in;
   logic [MASK_W-1:0] disabled_ff;
   logic [4:0]        status_ff, status_in;
   logic              centre_ff, centre_in;
   link_type          fin_ff;
   logic              fin_load;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_load;
   logic              accept;
   link_type          chain [0:CELL_COUNT];
   logic              in_range;
   logic              dis_bit;
   logic [31:0]       dis_wide;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // token launched into the first cell
   assign chain[0] = {accept, req_data.command, req_data.slot_index,
                      req_data.control_code, 1'b0, SLOT_W'(0), 1'b0};

   // row of slot cells
   for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
      fesm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (SLOT_W'(FIRST_SLOT + k)),
         .link_prev (chain[k]),
         .link_next (chain[k+1])
      );
   end

   // index checks on the finished token
   assign in_range = (fin_ff.idx >= 8'(FIRST_SLOT)) && (fin_ff.idx <= 8'(SLOT_COUNT));
   assign dis_wide = 32'(disabled_ff);
   assign dis_bit = (fin_ff.idx <= 8'd16) && dis_wide[fin_ff.idx[4:0]];

   // sequencer, result build and status update
   always_comb begin
      state_in = state_ff;
      fin_load = 1'b0;
      rsp_load = 1'b0;
      status_in = status_ff;
      centre_in = centre_ff;
      rsp_in = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (chain[CELL_COUNT].valid) begin
               fin_load = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      unique case (fin_ff.cmd)
         CMD_CREATE: begin
            if (fin_ff.found) begin
               rsp_in.new_index = 5'(fin_ff.new_idx);
               centre_in = 1'b0;
            end else begin
               rsp_in.load_status = 1'b1;
            end
         end
         CMD_START: begin
            if (fin_ff.idx == ALL_INDEX) begin
               rsp_in.notify_start = 1'b1;
               rsp_in.notify_index = ALL_NOTICE;
            end else if (in_range && !dis_bit) begin
               rsp_in.notify_start = 1'b1;
               rsp_in.notify_index = 7'(fin_ff.idx);
            end
         end
         CMD_SOLO: begin
            if ((fin_ff.idx == ALL_INDEX) || (in_range && !dis_bit)) begin
               rsp_in.notify_start = 1'b1;
               rsp_in.notify_stop = 1'b1;
               rsp_in.notify_index = ALL_NOTICE;
            end
         end
         CMD_STOP: begin
            if (in_range && fin_ff.hit_alloc && !dis_bit) begin
               rsp_in.notify_stop = 1'b1;
               rsp_in.notify_index = 7'(fin_ff.idx);
            end
         end
         CMD_FREE: begin
            if (fin_ff.idx == ALL_INDEX) begin
               rsp_in.notify_free = 1'b1;
               rsp_in.notify_index = ALL_NOTICE;
            end else begin
               centre_in = 1'b1;
               if (in_range) begin
                  rsp_in.notify_free = 1'b1;
                  rsp_in.notify_index = 7'(fin_ff.idx);
               end
            end
         end
         CMD_CTRL: begin
            status_in = status_ff | ST_SAFETY | ST_POWER;
            unique case (fin_ff.ctl)
               CTL_DISABLE: status_in = status_in & ~ST_ENABLED;
               CTL_ENABLE: status_in = status_in | ST_ENABLED;
               CTL_STOP_ALL: centre_in = 1'b0;
               CTL_RESET: centre_in = 1'b1;
               CTL_PAUSE: status_in = status_in | ST_PAUSED;
               CTL_CONTINUE: status_in = status_in & ~ST_PAUSED;
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      rsp_in.device_status = status_in;
      rsp_in.auto_centre = centre_in;

      // device status and auto-centre only move when the result is loaded
      if (!rsp_load) begin
         status_in = status_ff;
         centre_in = centre_ff;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         disabled_ff <= '0;
         status_ff <= '0;
         centre_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) disabled_ff <= csr_wr_data;
         status_ff <= status_in;
         centre_ff <= centre_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fin_load) fin_ff <= chain[CELL_COUNT];
      if (rsp_load) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   // token leaves the last cell only while the sequencer waits for it
   a_end_in_run: assert property (@(posedge clock) disable iff (reset)
      chain[CELL_COUNT].valid |-> (state_ff == ST_RUN))
      else $error("token left the cell row outside the run state");

   // an accepted item enters the first cell
   a_launch: assert property (@(posedge clock) disable iff (reset)
      accept |=> chain[1].valid)
      else $error("accepted item did not enter the cell row");

   // a new result only comes out of the finish state
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_load) |-> (state_ff == ST_FINISH) && !fin_load)
      else $error("result loaded outside the finish state");

   // full pool never reports a slot
   a_full_no_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.load_status |-> (rsp_ff.new_index == 5'd0))
      else $error("pool full result carries a slot index");
`endif

endmodule
`default_nettype wire
